/* src/depth_to_point_backproject_top_macros.svh */
// assertion macros for the depth back-projection block
// used by depth_to_point_backproject_top; expects clk_i and rst_ni in scope
`ifndef DEPTH_TO_POINT_BACKPROJECT_TOP_MACROS_SVH
`define DEPTH_TO_POINT_BACKPROJECT_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define DTPB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DTPB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dtpb_pkg.sv */
// shared types, constants and helpers for the depth back-projection block
// no dependencies
package dtpb_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned SizeW    = 13;
  localparam int unsigned CntW     = 12;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned InvW     = 24;
  localparam int unsigned CtrW     = 16;
  localparam int unsigned CoordW   = 30;
  localparam int unsigned Prod1W   = CtrW + DepthW;
  localparam int unsigned Prod2W   = Prod1W + InvW;
  localparam int unsigned FracW    = 28;
  localparam int unsigned KeepW    = Prod2W - (FracW - 1);
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam int unsigned QCntW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_INV_FOCAL_X  = 4'd2,
    REG_INV_FOCAL_Y  = 4'd3,
    REG_CENTER_X     = 4'd4,
    REG_CENTER_Y     = 4'd5,
    REG_NO_SAMPLE    = 4'd6,
    REG_SHADOW       = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL_A,
    BK_MUL_B,
    BK_ROUND
  } back_state_e;

  typedef struct packed {
    logic [SizeW-1:0]  frame_width;
    logic [SizeW-1:0]  frame_height;
    logic [InvW-1:0]   inv_focal_x;
    logic [InvW-1:0]   inv_focal_y;
    logic [CtrW-1:0]   center_x;
    logic [CtrW-1:0]   center_y;
    logic [DepthW-1:0] no_sample_code;
    logic [DepthW-1:0] shadow_code;
  } dtpb_cfg_t;

  // one classified pixel waiting for the multipliers
  typedef struct packed {
    logic [CtrW-1:0]   mag_x;
    logic              neg_x;
    logic [CtrW-1:0]   mag_y;
    logic              neg_y;
    logic [DepthW-1:0] depth;
    logic              valid;
    logic              frame_end;
  } dtpb_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dtpb_qstat_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* src/dtpb_cfg.sv */
// configuration register file for the depth back-projection block
// depends on dtpb_pkg
module dtpb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [dtpb_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [dtpb_pkg::CfgDataW-1:0] wr_data_i,
  output dtpb_pkg::dtpb_cfg_t           cfg_o
);

  dtpb_pkg::dtpb_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (dtpb_pkg::cfg_reg_e'(wr_index_i))
        dtpb_pkg::REG_FRAME_WIDTH:  cfg_d.frame_width    = wr_data_i[dtpb_pkg::SizeW-1:0];
        dtpb_pkg::REG_FRAME_HEIGHT: cfg_d.frame_height   = wr_data_i[dtpb_pkg::SizeW-1:0];
        dtpb_pkg::REG_INV_FOCAL_X:  cfg_d.inv_focal_x    = wr_data_i[dtpb_pkg::InvW-1:0];
        dtpb_pkg::REG_INV_FOCAL_Y:  cfg_d.inv_focal_y    = wr_data_i[dtpb_pkg::InvW-1:0];
        dtpb_pkg::REG_CENTER_X:     cfg_d.center_x       = wr_data_i[dtpb_pkg::CtrW-1:0];
        dtpb_pkg::REG_CENTER_Y:     cfg_d.center_y       = wr_data_i[dtpb_pkg::CtrW-1:0];
        dtpb_pkg::REG_NO_SAMPLE:    cfg_d.no_sample_code = wr_data_i[dtpb_pkg::DepthW-1:0];
        dtpb_pkg::REG_SHADOW:       cfg_d.shadow_code    = wr_data_i[dtpb_pkg::DepthW-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= 13'd640;
      cfg_q.frame_height   <= 13'd480;
      cfg_q.inv_focal_x    <= 24'd31957;
      cfg_q.inv_focal_y    <= 24'd31957;
      cfg_q.center_x       <= 16'd5112;
      cfg_q.center_y       <= 16'd3832;
      cfg_q.no_sample_code <= 16'd0;
      cfg_q.shadow_code    <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/dtpb_front.sv */
// front end: takes depth samples, tracks pixel position, classifies the sample
// and forms the centre offsets; depends on dtpb_pkg
module dtpb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dtpb_pkg::dtpb_cfg_t         cfg_i,
  input  logic                        in_valid_i,
  input  logic [dtpb_pkg::DepthW-1:0] depth_sample_i,
  output logic                        in_stall_o,
  input  dtpb_pkg::dtpb_qstat_t       q_stat_i,
  output logic                        push_o,
  output dtpb_pkg::dtpb_entry_t       entry_o
);

  logic [dtpb_pkg::CntW-1:0]  col_q, col_d, row_q, row_d;
  logic [dtpb_pkg::SizeW-1:0] width, height;
  logic                       last_col, last_row, accept, sample_ok;
  logic [dtpb_pkg::CtrW-1:0]  p16_x, p16_y;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;
  assign push_o     = accept;

  assign width  = dtpb_pkg::clamp_size(cfg_i.frame_width, dtpb_pkg::SizeW'(dtpb_pkg::MaxWidth));
  assign height = dtpb_pkg::clamp_size(cfg_i.frame_height,
                                       dtpb_pkg::SizeW'(dtpb_pkg::MaxHeight));

  // a counter left beyond a lowered size counts as the last position
  assign last_col = ({1'b0, col_q} + dtpb_pkg::SizeW'(1)) >= width;
  assign last_row = ({1'b0, row_q} + dtpb_pkg::SizeW'(1)) >= height;

  assign sample_ok = (depth_sample_i != '0) &&
                     (depth_sample_i != cfg_i.no_sample_code) &&
                     (depth_sample_i != cfg_i.shadow_code);

  assign p16_x = {col_q, 4'b0000};
  assign p16_y = {row_q, 4'b0000};

  always_comb begin
    entry_o.valid     = sample_ok;
    entry_o.frame_end = last_col & last_row;
    entry_o.neg_x     = 1'b0;
    entry_o.neg_y     = 1'b0;
    entry_o.mag_x     = '0;
    entry_o.mag_y     = '0;
    entry_o.depth     = '0;
    // invalid samples go through with zero operands, so the products come out zero
    if (sample_ok) begin
      entry_o.depth = depth_sample_i;
      entry_o.neg_x = p16_x < cfg_i.center_x;
      entry_o.neg_y = p16_y < cfg_i.center_y;
      entry_o.mag_x = entry_o.neg_x ? (cfg_i.center_x - p16_x) : (p16_x - cfg_i.center_x);
      entry_o.mag_y = entry_o.neg_y ? (cfg_i.center_y - p16_y) : (p16_y - cfg_i.center_y);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + dtpb_pkg::CntW'(1);
      end else begin
        col_d = col_q + dtpb_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* src/dtpb_fifo.sv */
// short register queue between the front and back ends
// depends on dtpb_pkg
module dtpb_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dtpb_pkg::dtpb_entry_t wr_data_i,
  input  logic                  pop_i,
  output dtpb_pkg::dtpb_entry_t rd_data_o,
  output dtpb_pkg::dtpb_qstat_t stat_o
);

  dtpb_pkg::dtpb_entry_t          mem_q [dtpb_pkg::QDepth];
  logic [dtpb_pkg::QAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [dtpb_pkg::QCntW-1:0]     cnt_q;
  logic                           do_push, do_pop;

  assign stat_o.full  = cnt_q == dtpb_pkg::QCntW'(dtpb_pkg::QDepth);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign rd_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + dtpb_pkg::QAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + dtpb_pkg::QAw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + dtpb_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - dtpb_pkg::QCntW'(1);
      end
    end
  end

endmodule

/* src/dtpb_back.sv */
// back end: two multiply steps, rounding and sign, then the output register
// depends on dtpb_pkg
module dtpb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dtpb_pkg::dtpb_cfg_t          cfg_i,
  input  dtpb_pkg::dtpb_entry_t        entry_i,
  input  dtpb_pkg::dtpb_qstat_t        q_stat_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dtpb_pkg::CoordW-1:0]  point_x_o,
  output logic [dtpb_pkg::CoordW-1:0]  point_y_o,
  output logic [dtpb_pkg::DepthW-1:0]  point_z_o,
  output logic                         point_valid_o,
  output logic                         frame_end_o
);

  dtpb_pkg::back_state_e state_q, state_d;
  dtpb_pkg::dtpb_entry_t ent_q;

  logic [dtpb_pkg::Prod1W-1:0] p1x_q, p1y_q;
  logic [dtpb_pkg::KeepW-1:0]  p2x_q, p2y_q;
  logic [dtpb_pkg::Prod2W-1:0] mulx, muly;
  logic [dtpb_pkg::KeepW:0]    sumx, sumy;
  logic [dtpb_pkg::CoordW-1:0] magx, magy, px, py;
  logic                        load, out_valid_q;

  logic [dtpb_pkg::CoordW-1:0] px_q, py_q;
  logic [dtpb_pkg::DepthW-1:0] pz_q;
  logic                        pv_q, fe_q;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    case (state_q)
      dtpb_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = dtpb_pkg::BK_MUL_A;
        end
      end
      dtpb_pkg::BK_MUL_A: state_d = dtpb_pkg::BK_MUL_B;
      dtpb_pkg::BK_MUL_B: state_d = dtpb_pkg::BK_ROUND;
      dtpb_pkg::BK_ROUND: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = dtpb_pkg::BK_IDLE;
        end
      end
      default: state_d = dtpb_pkg::BK_IDLE;
    endcase
  end

  assign mulx = dtpb_pkg::Prod2W'(p1x_q) * dtpb_pkg::Prod2W'(cfg_i.inv_focal_x);
  assign muly = dtpb_pkg::Prod2W'(p1y_q) * dtpb_pkg::Prod2W'(cfg_i.inv_focal_y);

  // kept bits start at 2^27: add one there and drop it for round half up
  assign sumx = {1'b0, p2x_q} + (dtpb_pkg::KeepW + 1)'(1);
  assign sumy = {1'b0, p2y_q} + (dtpb_pkg::KeepW + 1)'(1);
  assign magx = dtpb_pkg::CoordW'(sumx[dtpb_pkg::KeepW:1]);
  assign magy = dtpb_pkg::CoordW'(sumy[dtpb_pkg::KeepW:1]);
  assign px   = ent_q.neg_x ? (~magx + dtpb_pkg::CoordW'(1)) : magx;
  assign py   = ent_q.neg_y ? (~magy + dtpb_pkg::CoordW'(1)) : magy;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
    if (state_q == dtpb_pkg::BK_MUL_A) begin
      p1x_q <= dtpb_pkg::Prod1W'(ent_q.mag_x) * dtpb_pkg::Prod1W'(ent_q.depth);
      p1y_q <= dtpb_pkg::Prod1W'(ent_q.mag_y) * dtpb_pkg::Prod1W'(ent_q.depth);
    end
    if (state_q == dtpb_pkg::BK_MUL_B) begin
      p2x_q <= mulx[dtpb_pkg::Prod2W-1:dtpb_pkg::FracW-1];
      p2y_q <= muly[dtpb_pkg::Prod2W-1:dtpb_pkg::FracW-1];
    end
    if (load) begin
      px_q <= px;
      py_q <= py;
      pz_q <= ent_q.depth;
      pv_q <= ent_q.valid;
      fe_q <= ent_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtpb_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign point_z_o     = pz_q;
  assign point_valid_o = pv_q;
  assign frame_end_o   = fe_q;

endmodule

/* src/depth_to_point_backproject_top.sv */
// channel   dir  handshake                  payload
// --------  ---  -------------------------  ----------------------------------------
// in        in   in_valid_i / in_stall_o    depth_sample_i
// out       out  out_valid_o / out_stall_i  point_x_o point_y_o point_z_o
//                                           point_valid_o frame_end_o
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i cfg_data_i
//
// each point passes the back end in order (queue read, two multiply steps, round into
// the output register, held while the output is stalled); then the next point is read.
// a four-entry queue lets the front keep taking samples while the back end works.
// reset zeroes the pixel counters and loads the default intrinsics; no clearing pass.
// in_stall_o is high while the queue is full; cfg_ready_o is always high.
// depends on dtpb_pkg, dtpb_cfg, dtpb_front, dtpb_fifo, dtpb_back and the macro header
`include "depth_to_point_backproject_top_macros.svh"

module depth_to_point_backproject_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dtpb_pkg::DepthW-1:0]   depth_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [dtpb_pkg::CoordW-1:0] point_x_o,
  output logic signed [dtpb_pkg::CoordW-1:0] point_y_o,
  output logic [dtpb_pkg::DepthW-1:0]   point_z_o,
  output logic                          point_valid_o,
  output logic                          frame_end_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtpb_pkg::CfgDataW-1:0] cfg_data_i
);

  dtpb_pkg::dtpb_cfg_t   cfg;
  dtpb_pkg::dtpb_entry_t push_word, pop_word;
  dtpb_pkg::dtpb_qstat_t q_stat;
  logic                  push, pop;
  logic [dtpb_pkg::CoordW-1:0] px, py;

  assign cfg_ready_o = 1'b1;

  dtpb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  dtpb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .depth_sample_i (depth_sample_i),
    .in_stall_o     (in_stall_o),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .entry_o        (push_word)
  );

  dtpb_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (push_word),
    .pop_i     (pop),
    .rd_data_o (pop_word),
    .stat_o    (q_stat)
  );

  dtpb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .entry_i       (pop_word),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_x_o     (px),
    .point_y_o     (py),
    .point_z_o     (point_z_o),
    .point_valid_o (point_valid_o),
    .frame_end_o   (frame_end_o)
  );

  assign point_x_o = $signed(px);
  assign point_y_o = $signed(py);

  // invalid measurements carry an all-zero point
  `DTPB_ASSERT_IMPL(a_invalid_zero, out_valid_o && !point_valid_o, (point_x_o == 0) && (point_y_o == 0) && (point_z_o == 0), "invalid point with nonzero coordinates")
  // a valid point never has zero depth
  `DTPB_ASSERT_IMPL(a_valid_depth, out_valid_o && point_valid_o, point_z_o != 0, "valid point with zero depth")
  // an accepted sample with no queue read alongside it leaves the queue non-empty
  `DTPB_ASSERT_NEXT(a_push_lands, push && !pop && !q_stat.full, !q_stat.empty, "accepted sample lost before the queue")
  // the back end only reads when the queue holds something
  `DTPB_ASSERT_IMPL(a_pop_nonempty, pop, !q_stat.empty, "queue read while empty")

endmodule
